### hdl/indexed_array_list_unit_macros.svh
// assertion macros shared by the list unit rtl
`ifndef INDEXED_ARRAY_LIST_UNIT_MACROS_SVH
`define INDEXED_ARRAY_LIST_UNIT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define IAL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// implication checked in the cycle after the antecedent, outside reset
`define IAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/ial_pkg.sv
// types, codes and constants of the indexed array list unit
`timescale 1ns / 1ps

package ial_pkg;

  localparam int DEF_CAPACITY    = 64;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int REQ_W    = 3;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 6;
  localparam int READ_W   = 32;
  localparam int LEN_W    = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_SEARCH = 3'd2,
    REQ_READ   = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_e_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_RANGE    = 2'd2,
    STATUS_NOTFOUND = 2'd3
  } status_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_DONE
  } state_e_t;

  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic search;
    logic read;
  } cell_cmd_t;

endpackage

### hdl/ial_cell.sv
// one list cell: holds an entry, shifts with its neighbours, flags a hit
`timescale 1ns / 1ps

module ial_cell #(
  parameter int VW    = ial_pkg::DEF_VALUE_WIDTH,
  parameter int CW    = 7,
  parameter int PW    = 7,
  parameter int INDEX = 0
) (
  input  logic                 clk,
  input  ial_pkg::cell_cmd_t   cmd,
  input  logic [PW-1:0]        pos,
  input  logic [CW-1:0]        count,
  input  logic [VW-1:0]        din,
  input  logic [VW-1:0]        from_lower,
  input  logic [VW-1:0]        from_upper,
  output logic [VW-1:0]        entry,
  output logic                 hit
);

  localparam logic [PW-1:0] IDX_P = PW'(INDEX);
  localparam logic [CW-1:0] IDX_C = CW'(INDEX);

  always_ff @(posedge clk) begin
    if (cmd.shift_up) begin
      if (IDX_P > pos) begin
        entry <= from_lower;
      end else if (IDX_P == pos) begin
        entry <= din;
      end
    end else if (cmd.shift_down && (IDX_P >= pos)) begin
      entry <= from_upper;
    end
  end

  assign hit = (cmd.search && (entry == din) && (IDX_C < count)) ||
               (cmd.read && (IDX_P == pos));

endmodule

### hdl/ial_tree.sv
// registered priority tree picking the lowest-index hit and its entry
`timescale 1ns / 1ps

module ial_tree #(
  parameter int CAPACITY = ial_pkg::DEF_CAPACITY,
  parameter int VW       = ial_pkg::DEF_VALUE_WIDTH
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic [CAPACITY-1:0]        leaf_hit,
  input  logic [CAPACITY*VW-1:0]     leaf_data,
  output logic                       root_hit,
  output logic [$clog2(CAPACITY)-1:0] root_index,
  output logic [VW-1:0]              root_data
);

  localparam int LOG   = $clog2(CAPACITY);
  localparam int N     = 2 ** LOG;
  localparam int NODES = 2 * N - 1;

  logic           node_hit  [NODES];
  logic [VW-1:0]  node_data [NODES];
  logic [LOG-1:0] node_idx  [NODES];

  for (genvar j = 0; j < N; j++) begin : g_leaf
    always_ff @(posedge clk) begin
      if (load) begin
        if (j < CAPACITY) begin
          node_hit[N-1+j]  <= leaf_hit[j % CAPACITY];
          node_data[N-1+j] <= leaf_data[(j % CAPACITY)*VW +: VW];
        end else begin
          node_hit[N-1+j]  <= 1'b0;
          node_data[N-1+j] <= '0;
        end
        node_idx[N-1+j] <= LOG'(j);
      end
    end
  end

  for (genvar i = 0; i < N - 1; i++) begin : g_node
    always_ff @(posedge clk) begin
      node_hit[i] <= node_hit[2*i+1] | node_hit[2*i+2];
      if (node_hit[2*i+1]) begin
        node_idx[i]  <= node_idx[2*i+1];
        node_data[i] <= node_data[2*i+1];
      end else begin
        node_idx[i]  <= node_idx[2*i+2];
        node_data[i] <= node_data[2*i+2];
      end
    end
  end

  assign root_hit   = node_hit[0];
  assign root_index = node_idx[0];
  assign root_data  = node_data[0];

endmodule

### hdl/indexed_array_list_unit.sv
// top level of the indexed array list unit: cell row, hit tree and control
//
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | tuser req_type, tdata position, value
//  m_*     | out | m_tvalid/m_tready | tdata status, found_index, read_value, list_length
//
// one request at a time; the wait from acceptance to its result beat is
// set by the depth of the registered hit tree
// the next request is taken in the cycle after the result beat leaves
// rst clears the length and the control; entries are not cleared
// m_tready low holds the result and keeps s_tready low
`timescale 1ns / 1ps

`include "indexed_array_list_unit_macros.svh"

module indexed_array_list_unit #(
  parameter int CAPACITY    = ial_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = ial_pkg::DEF_VALUE_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[6:0], value[38:7], zero[39]
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // status[1:0], found_index[7:2], read_value[39:8],
                                 // list_length[46:40], zero[47]
);

  localparam int VW  = VALUE_WIDTH;
  localparam int LOG = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = (CW > ial_pkg::POS_W) ? CW : ial_pkg::POS_W;
  localparam int XW  = (VW > ial_pkg::VAL_W) ? VW : ial_pkg::VAL_W;
  localparam int IW  = (LOG > ial_pkg::FOUND_W) ? LOG : ial_pkg::FOUND_W;
  localparam int LW  = (CW > ial_pkg::LEN_W) ? CW : ial_pkg::LEN_W;
  localparam int TW  = $clog2(LOG + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  ial_pkg::state_e_t  state, state_next;
  ial_pkg::req_e_t    req;
  ial_pkg::req_e_t    pend_req;
  ial_pkg::status_e_t pend_status, acc_status;
  ial_pkg::status_e_t out_status;
  ial_pkg::cell_cmd_t cmd;

  logic                 accept;
  logic                 tree_done;
  logic [TW-1:0]        wait_cnt;
  logic [CW-1:0]        count;
  logic [PW-1:0]        pos_ext;
  logic [PW-1:0]        count_ext;
  logic [XW-1:0]        val_wide;
  logic [VW-1:0]        val_in;
  logic                 ins_ok, rem_ok;

  logic [VW-1:0]        entry [CAPACITY];
  logic [CAPACITY-1:0]  hit;
  logic [CAPACITY*VW-1:0] leaf_data;
  logic                 root_hit;
  logic [LOG-1:0]       root_index;
  logic [VW-1:0]        root_data;

  logic [IW-1:0]        idx_wide;
  logic [XW-1:0]        rd_wide;
  logic [LW-1:0]        len_wide;
  logic [ial_pkg::FOUND_W-1:0] out_found;
  logic [ial_pkg::READ_W-1:0]  out_read;
  logic [ial_pkg::LEN_W-1:0]   out_length;
  logic                 found_bad;
  logic                 full_ins;

  assign accept    = s_tvalid && s_tready;
  assign req       = ial_pkg::req_e_t'(s_tuser);
  assign pos_ext   = PW'(s_tdata[6:0]);
  assign count_ext = PW'(count);
  assign val_wide  = XW'(s_tdata[38:7]);
  assign val_in    = val_wide[VW-1:0];

  assign ins_ok = (req == ial_pkg::REQ_INSERT) && (count < CAP_C) && (pos_ext <= count_ext);
  assign rem_ok = (req == ial_pkg::REQ_REMOVE) && (pos_ext < count_ext);

  always_comb begin
    acc_status = ial_pkg::STATUS_OK;
    case (req)
      ial_pkg::REQ_INSERT: begin
        if (count >= CAP_C) begin
          acc_status = ial_pkg::STATUS_FULL;
        end else if (pos_ext > count_ext) begin
          acc_status = ial_pkg::STATUS_RANGE;
        end
      end
      ial_pkg::REQ_REMOVE, ial_pkg::REQ_READ: begin
        if (pos_ext >= count_ext) begin
          acc_status = ial_pkg::STATUS_RANGE;
        end
      end
      default: acc_status = ial_pkg::STATUS_OK;
    endcase
  end

  assign cmd.shift_up   = accept && ins_ok;
  assign cmd.shift_down = accept && rem_ok;
  assign cmd.search     = (req == ial_pkg::REQ_SEARCH);
  assign cmd.read       = (req == ial_pkg::REQ_READ);

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [VW-1:0] lower, upper;
    if (k == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = entry[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = entry[k+1];
    end

    ial_cell #(
      .VW    (VW),
      .CW    (CW),
      .PW    (PW),
      .INDEX (k)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (pos_ext),
      .count      (count),
      .din        (val_in),
      .from_lower (lower),
      .from_upper (upper),
      .entry      (entry[k]),
      .hit        (hit[k])
    );

    assign leaf_data[k*VW +: VW] = entry[k];
  end

  ial_tree #(
    .CAPACITY (CAPACITY),
    .VW       (VW)
  ) u_tree (
    .clk        (clk),
    .load       (accept),
    .leaf_hit   (hit),
    .leaf_data  (leaf_data),
    .root_hit   (root_hit),
    .root_index (root_index),
    .root_data  (root_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ial_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    tree_done  = 1'b0;
    case (state)
      ial_pkg::ST_IDLE: begin
        s_tready = !rst;
        if (accept) begin
          state_next = ial_pkg::ST_BUSY;
        end
      end
      ial_pkg::ST_BUSY: begin
        if (wait_cnt == '0) begin
          tree_done  = 1'b1;
          state_next = ial_pkg::ST_DONE;
        end
      end
      ial_pkg::ST_DONE: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = ial_pkg::ST_IDLE;
        end
      end
      default: state_next = ial_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      wait_cnt <= '0;
    end else begin
      if (accept) begin
        wait_cnt <= TW'(LOG);
        if (ins_ok) begin
          count <= count + 1'b1;
        end else if (rem_ok) begin
          count <= count - 1'b1;
        end else if (req == ial_pkg::REQ_CLEAR) begin
          count <= '0;
        end
      end else if (state == ial_pkg::ST_BUSY && wait_cnt != '0) begin
        wait_cnt <= wait_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_req    <= req;
      pend_status <= acc_status;
    end
  end

  assign idx_wide = IW'(root_index);
  assign rd_wide  = XW'(root_data);
  assign len_wide = LW'(count);

  always_ff @(posedge clk) begin
    if (tree_done) begin
      out_length <= len_wide[ial_pkg::LEN_W-1:0];
      if (pend_req == ial_pkg::REQ_SEARCH) begin
        out_read <= '0;
        if (root_hit) begin
          out_status <= ial_pkg::STATUS_OK;
          out_found  <= idx_wide[ial_pkg::FOUND_W-1:0];
        end else begin
          out_status <= ial_pkg::STATUS_NOTFOUND;
          out_found  <= '0;
        end
      end else begin
        out_status <= pend_status;
        out_found  <= '0;
        if (pend_req == ial_pkg::REQ_READ && pend_status == ial_pkg::STATUS_OK) begin
          out_read <= rd_wide[ial_pkg::READ_W-1:0];
        end else begin
          out_read <= '0;
        end
      end
    end
  end

  assign m_tdata = {1'b0, out_length, out_read, out_found, out_status};

  assign found_bad = m_tvalid && (out_found != '0) && (out_status != ial_pkg::STATUS_OK);
  assign full_ins  = accept && (req == ial_pkg::REQ_INSERT) && (count == CAP_C);

  `IAL_ASSERT_ALWAYS(a_one_at_a_time, !(s_tready && m_tvalid), "ready while result pending")
  `IAL_ASSERT_ALWAYS(a_count_bound, count <= CAP_C, "length beyond capacity")
  `IAL_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "second request taken while busy")
  `IAL_ASSERT_ALWAYS(a_found_ok, !found_bad, "found index with error status")
  `IAL_ASSERT_NEXT(a_full_holds, full_ins, $stable(count), "insert into full list changed length")

endmodule

### tb/tb_indexed_array_list_unit.sv
// testbench of the indexed array list unit: directed table, random requests, shadow list check
`timescale 1ns / 1ps

module tb_indexed_array_list_unit;
  import ial_pkg::*;

  localparam int LIST_CAP = DEF_CAPACITY;
  localparam int RANDOM_BEATS = 870;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;

  // request codes the block ignores
  localparam logic [REQ_W-1:0] REQ_SPARE5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

  typedef struct packed {
    status_e_t          status;
    logic [FOUND_W-1:0] found;
    logic [READ_W-1:0]  rd;
    logic [LEN_W-1:0]   len;
  } list_result_t;

  typedef struct packed {
    logic [REQ_W-1:0]  rq;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    bit                typed;
    status_e_t         status;
    logic [READ_W-1:0] rd;
    logic [LEN_W-1:0]  len;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  logic [VAL_W-1:0] shadow_list [LIST_CAP];
  int               shadow_len = 0;
  list_result_t     list_pending [$];
  int               mismatches = 0;
  int               useful_beats = 0;
  int               send_idle_pct = 15;
  int               recv_idle_pct = 45;
  bit               hold_req = 1'b0;
  bit               hold_done = 1'b0;
  int               hold_left = 0;
  stim_row_t        dir_rows [25];

  indexed_array_list_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  function automatic list_result_t apply_list_request(logic [REQ_W-1:0] rq,
                                                      logic [POS_W-1:0] pos,
                                                      logic [VAL_W-1:0] val);
    list_result_t r;
    int k;
    r.status = STATUS_OK;
    r.found = '0;
    r.rd = '0;
    case (rq)
      REQ_INSERT: begin
        if (shadow_len >= LIST_CAP) begin
          r.status = STATUS_FULL;
        end else if (int'(pos) > shadow_len) begin
          r.status = STATUS_RANGE;
        end else begin
          for (k = shadow_len; k > int'(pos); k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[pos] = val;
          shadow_len++;
        end
      end
      REQ_REMOVE: begin
        if (int'(pos) >= shadow_len) begin
          r.status = STATUS_RANGE;
        end else begin
          for (k = int'(pos); k + 1 < shadow_len; k++) shadow_list[k] = shadow_list[k+1];
          shadow_len--;
        end
      end
      REQ_SEARCH: begin
        r.status = STATUS_NOTFOUND;
        for (k = 0; k < shadow_len; k++) begin
          if (shadow_list[k] == val) begin
            r.status = STATUS_OK;
            r.found = k[FOUND_W-1:0];
            break;
          end
        end
      end
      REQ_READ: begin
        if (int'(pos) >= shadow_len) r.status = STATUS_RANGE;
        else r.rd = shadow_list[pos];
      end
      REQ_CLEAR: shadow_len = 0;
      default: ;
    endcase
    r.len = shadow_len[LEN_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // result side: random stalls, long hold-off on request
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (list_pending.size() == 0) begin
          report_mismatch("unexpected beat", m_tdata[31:0], 32'd0);
        end else begin
          want = list_pending.pop_front();
          if (m_tdata[1:0] !== want.status)
            report_mismatch("status", m_tdata[1:0], want.status);
          if (m_tdata[7:2] !== want.found)
            report_mismatch("found_index", m_tdata[7:2], want.found);
          if (m_tdata[39:8] !== want.rd)
            report_mismatch("read_value", m_tdata[39:8], want.rd);
          if (m_tdata[46:40] !== want.len)
            report_mismatch("list_length", m_tdata[46:40], want.len);
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_request(logic [REQ_W-1:0] rq, logic [POS_W-1:0] pos,
                              logic [VAL_W-1:0] val, bit typed, list_result_t typed_res);
    list_result_t r;
    s_tvalid <= 1'b1;
    s_tuser <= rq;
    s_tdata <= {1'b0, val, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = apply_list_request(rq, pos, val);
    list_pending.push_back(typed ? typed_res : r);
    if (rq <= REQ_CLEAR) useful_beats++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_plain(logic [REQ_W-1:0] rq, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
    send_request(rq, pos, val, 1'b0, '0);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 45) return VAL_W'($urandom_range(0, 7));
    if (sel < 50) return '1;
    return $urandom;
  endfunction

  task automatic fill_list();
    while (shadow_len < LIST_CAP)
      send_plain(REQ_INSERT, POS_W'($urandom_range(0, shadow_len)), pick_value());
    // full takes priority over a bad position
    send_plain(REQ_INSERT, POS_W'($urandom_range(0, 127)), pick_value());
    send_plain(REQ_INSERT, POS_W'(LIST_CAP), pick_value());
  endtask

  task automatic drain_list();
    if ($urandom_range(1)) begin
      while (shadow_len > 0)
        send_plain(REQ_REMOVE, POS_W'($urandom_range(0, shadow_len - 1)), $urandom);
    end else begin
      send_plain(REQ_CLEAR, POS_W'($urandom_range(0, 127)), $urandom);
    end
  endtask

  task automatic send_wellformed();
    int op;
    logic [VAL_W-1:0] v;
    op = $urandom_range(99);
    if (op < 35) begin
      send_plain(REQ_INSERT, POS_W'($urandom_range(0, shadow_len)), pick_value());
    end else if (op < 55) begin
      send_plain(REQ_REMOVE,
                 POS_W'(shadow_len > 0 ? $urandom_range(0, shadow_len - 1) : 0), $urandom);
    end else if (op < 75) begin
      v = pick_value();
      if (shadow_len > 0 && $urandom_range(99) < 70)
        v = shadow_list[$urandom_range(0, shadow_len - 1)];
      send_plain(REQ_SEARCH, POS_W'($urandom_range(0, 127)), v);
    end else if (op < 97) begin
      send_plain(REQ_READ,
                 POS_W'(shadow_len > 0 ? $urandom_range(0, shadow_len - 1) : 0), $urandom);
    end else begin
      send_plain(REQ_CLEAR, POS_W'($urandom_range(0, 127)), $urandom);
    end
  endtask

  initial begin
    list_result_t tr;
    int sel;
    bit held;
    bit paused;
    held = 1'b0;
    paused = 1'b0;
    dir_rows = '{
      '{REQ_READ,   7'd0,   32'd0,          1'b1, STATUS_RANGE,    32'd0,          7'd0},
      '{REQ_REMOVE, 7'd0,   32'd0,          1'b1, STATUS_RANGE,    32'd0,          7'd0},
      '{REQ_SEARCH, 7'd0,   32'd0,          1'b1, STATUS_NOTFOUND, 32'd0,          7'd0},
      '{REQ_INSERT, 7'd1,   32'd0,          1'b1, STATUS_RANGE,    32'd0,          7'd0},
      '{REQ_CLEAR,  7'd0,   32'd0,          1'b1, STATUS_OK,       32'd0,          7'd0},
      '{REQ_INSERT, 7'd0,   32'hFFFF_FFFF,  1'b1, STATUS_OK,       32'd0,          7'd1},
      '{REQ_INSERT, 7'd1,   32'd0,          1'b1, STATUS_OK,       32'd0,          7'd2},
      '{REQ_INSERT, 7'd0,   32'h1234_5678,  1'b1, STATUS_OK,       32'd0,          7'd3},
      '{REQ_READ,   7'd0,   32'd0,          1'b1, STATUS_OK,       32'h1234_5678,  7'd3},
      '{REQ_READ,   7'd1,   32'd0,          1'b1, STATUS_OK,       32'hFFFF_FFFF,  7'd3},
      '{REQ_READ,   7'd3,   32'd0,          1'b1, STATUS_RANGE,    32'd0,          7'd3},
      '{REQ_READ,   7'd127, 32'hFFFF_FFFF,  1'b1, STATUS_RANGE,    32'd0,          7'd3},
      '{REQ_INSERT, 7'd127, 32'd5,          1'b1, STATUS_RANGE,    32'd0,          7'd3},
      '{REQ_INSERT, 7'd3,   32'd0,          1'b0, STATUS_OK,       32'd0,          7'd0},
      '{REQ_SEARCH, 7'd0,   32'd0,          1'b0, STATUS_OK,       32'd0,          7'd0},
      '{REQ_SEARCH, 7'd0,   32'hFFFF_FFFF,  1'b0, STATUS_OK,       32'd0,          7'd0},
      '{REQ_SEARCH, 7'd0,   32'd7,          1'b1, STATUS_NOTFOUND, 32'd0,          7'd4},
      '{REQ_REMOVE, 7'd4,   32'd0,          1'b1, STATUS_RANGE,    32'd0,          7'd4},
      '{REQ_REMOVE, 7'd1,   32'd0,          1'b0, STATUS_OK,       32'd0,          7'd0},
      '{REQ_READ,   7'd1,   32'd0,          1'b0, STATUS_OK,       32'd0,          7'd0},
      '{REQ_SPARE5, 7'd127, 32'hFFFF_FFFF,  1'b1, STATUS_OK,       32'd0,          7'd3},
      '{REQ_SPARE6, 7'd0,   32'd0,          1'b1, STATUS_OK,       32'd0,          7'd3},
      '{REQ_SPARE7, 7'd85,  32'hAAAA_5555,  1'b1, STATUS_OK,       32'd0,          7'd3},
      '{REQ_REMOVE, 7'd0,   32'd0,          1'b0, STATUS_OK,       32'd0,          7'd0},
      '{REQ_CLEAR,  7'd127, 32'hFFFF_FFFF,  1'b1, STATUS_OK,       32'd0,          7'd0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      tr.status = dir_rows[i].status;
      tr.found = '0;
      tr.rd = dir_rows[i].rd;
      tr.len = dir_rows[i].len;
      send_request(dir_rows[i].rq, dir_rows[i].pos, dir_rows[i].val, dir_rows[i].typed, tr);
    end

    useful_beats = 0;
    fill_list();
    while (useful_beats < RANDOM_BEATS) begin
      if (useful_beats >= RANDOM_BEATS / 3 && useful_beats < 2 * RANDOM_BEATS / 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 15;
      end else if (useful_beats >= 2 * RANDOM_BEATS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (!held && useful_beats >= 150) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && useful_beats >= 450) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        while (list_pending.size() != 0) @(posedge clk);
      end
      sel = $urandom_range(99);
      if (sel < 3) fill_list();
      else if (sel < 6) drain_list();
      else if (sel < 85) send_wellformed();
      else send_plain(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)), $urandom);
    end
    s_tvalid <= 1'b0;

    while (list_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### indexed_array_list_unit.f
+incdir+hdl
hdl/ial_pkg.sv
hdl/ial_cell.sv
hdl/ial_tree.sv
hdl/indexed_array_list_unit.sv
tb/tb_indexed_array_list_unit.sv
